>>> hdl/pcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_pkg
// shared types, constants and register indexes of the pulse charge monitor
// ----------------------------------------------------------------------------
package pcm_pkg;

   // pulse framing
   localparam int SAMPLES_PER_PULSE = 10;
   localparam int IDX_W             = 4;
   localparam int SAMPLE_W          = 8;
   localparam int SUM_W             = 12;

   // field widths
   localparam int FREQ_W   = 16;
   localparam int UC_W     = 16;
   localparam int PCT_W    = 7;
   localparam int CHARGE_W = 19;
   localparam int EXACT_W  = 20;
   localparam int THRESH_W = 21;
   localparam int POWER_W  = 16;
   localparam int COUNT_W  = 16;

   // shared multiplier and serial divider
   localparam int MUL_A_W = 19;
   localparam int MUL_B_W = 16;
   localparam int DVD_W   = 35;
   localparam int DVS_W   = 16;
   localparam int CNT_W   = 6;
   localparam logic [CNT_W-1:0] DIV_LONG  = CNT_W'(35);
   localparam logic [CNT_W-1:0] DIV_SHORT = CNT_W'(23);
   localparam int DIV_ALIGN = 35 - 23;

   // arithmetic constants
   localparam logic [MUL_B_W-1:0]  CHARGE_MULT = MUL_B_W'(165);
   localparam logic [MUL_B_W-1:0]  POWER_MULT  = MUL_B_W'(9);
   localparam logic [DVS_W-1:0]    POWER_DIV   = DVS_W'(80);
   localparam logic [MUL_B_W-1:0]  PCT_MULT    = MUL_B_W'(100);
   localparam logic [CHARGE_W-1:0] CHARGE_MAX  = {CHARGE_W{1'b1}};

   // register reset values
   localparam logic [FREQ_W-1:0] TARGET_FREQ_RST = FREQ_W'(2000);
   localparam logic [FREQ_W-1:0] LP_FREQ_RST     = FREQ_W'(500);
   localparam logic [UC_W-1:0]   MAX_UC_RST      = UC_W'(2500);
   localparam logic [UC_W-1:0]   SPARK_UC_RST    = UC_W'(200);
   localparam logic [PCT_W-1:0]  ALERT_PCT_RST   = PCT_W'(25);

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_FREQ = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LP_FREQ     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_UC      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARK_UC    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ALERT_PCT   = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHARGE,
      ST_DECIDE,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      OP_AVG,
      OP_PWR,
      OP_SPK,
      OP_SHT
   } op_type;

endpackage

>>> hdl/pcm_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_req_if
// sample input channel: one current-sense sample per item
// ----------------------------------------------------------------------------
interface pcm_req_if;
   import pcm_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

>>> hdl/pcm_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_rsp_if
// pulse result channel: one item per completed pulse
// ----------------------------------------------------------------------------
interface pcm_rsp_if;
   import pcm_pkg::*;

   logic                valid;
   logic                ready;
   logic [CHARGE_W-1:0] charge_q;
   logic                is_short;
   logic                is_spark;
   logic                low_power;
   logic                freq_changed;
   logic [FREQ_W-1:0]   pulse_frequency;
   logic [CHARGE_W-1:0] avg_charge_q;
   logic [POWER_W-1:0]  power_mw;
   logic                window_done;
   logic [PCT_W-1:0]    spark_pct;
   logic [PCT_W-1:0]    short_pct;
   logic                short_alert;

   modport source (output valid, output charge_q, output is_short, output is_spark,
                   output low_power, output freq_changed, output pulse_frequency,
                   output avg_charge_q, output power_mw, output window_done,
                   output spark_pct, output short_pct, output short_alert,
                   input ready);
   modport sink   (input valid, input charge_q, input is_short, input is_spark,
                   input low_power, input freq_changed, input pulse_frequency,
                   input avg_charge_q, input power_mw, input window_done,
                   input spark_pct, input short_pct, input short_alert,
                   output ready);
endinterface

>>> hdl/pcm_csr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_csr_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface pcm_csr_if;
   import pcm_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/pulse_charge_monitor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_charge_monitor_unit
// per-pulse charge, mode switching, weighted average, power and window stats
// ----------------------------------------------------------------------------
// Samples are summed at one per cycle while idle; every SAMPLES_PER_PULSE-th
// sample closes a pulse and starts a sequencer that runs one shared 19x16
// multiplier and one restoring divider (one quotient bit per cycle). A
// closing sample keeps the input stalled through charge, decision, a
// 35-step average divide, a 23-step power divide, two more 23-step
// percentage divides when the pulse also closes a window, and the result
// load. The result sits in an output register, so sampling resumes while
// a result waits; a further closing sample waits at the load step until
// that result is taken. Charge is sum*165 in 1/32 uC; a charge above T uC
// means above T*32. Configuration writes are always taken and are meant
// to be issued only while the block is idle.
// ----------------------------------------------------------------------------
module pulse_charge_monitor_unit (
   input  logic   clock,
   input  logic   reset,
   pcm_req_if.sink   req_bus,
   pcm_rsp_if.source rsp_bus,
   pcm_csr_if.sink   csr_bus
);
   import pcm_pkg::*;

   // configuration registers
   logic [FREQ_W-1:0] target_freq_ff, target_freq_in;
   logic [FREQ_W-1:0] lp_freq_ff, lp_freq_in;
   logic [UC_W-1:0]   max_uc_ff, max_uc_in;
   logic [UC_W-1:0]   spark_uc_ff, spark_uc_in;
   logic [PCT_W-1:0]  alert_pct_ff, alert_pct_in;

   // pulse and window state
   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic                lp_ff, lp_in;
   logic [FREQ_W-1:0]   freq_ff, freq_in;
   logic [COUNT_W-1:0]  pulses_ff, pulses_in;
   logic [COUNT_W-1:0]  sparks_ff, sparks_in;
   logic [COUNT_W-1:0]  shorts_ff, shorts_in;
   logic [CHARGE_W-1:0] avg_ff, avg_in;
   logic [PCT_W-1:0]    spark_pct_ff, spark_pct_in;
   logic [PCT_W-1:0]    short_pct_ff, short_pct_in;

   // per-pulse working registers
   logic [EXACT_W-1:0]  charge_ff, charge_in;
   logic                short_ff, short_in;
   logic                spark_ff, spark_in;
   logic                changed_ff, changed_in;
   logic                done_ff, done_in;
   logic [POWER_W-1:0]  power_ff, power_in;

   // serial divider
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHARGE_W-1:0] rsp_charge_ff, rsp_charge_in;
   logic                rsp_short_ff, rsp_short_in;
   logic                rsp_spark_ff, rsp_spark_in;
   logic                rsp_lp_ff, rsp_lp_in;
   logic                rsp_changed_ff, rsp_changed_in;
   logic [FREQ_W-1:0]   rsp_freq_ff, rsp_freq_in;
   logic [CHARGE_W-1:0] rsp_avg_ff, rsp_avg_in;
   logic [POWER_W-1:0]  rsp_power_ff, rsp_power_in;
   logic                rsp_done_ff, rsp_done_in;
   logic [PCT_W-1:0]    rsp_spark_pct_ff, rsp_spark_pct_in;
   logic [PCT_W-1:0]    rsp_short_pct_ff, rsp_short_pct_in;
   logic                rsp_alert_ff, rsp_alert_in;

   // combinational helpers
   logic                req_fire;
   logic                csr_fire;
   logic [IDX_W-1:0]    idx_next;
   logic [SUM_W-1:0]    sum_next;
   logic [CHARGE_W-1:0] charge_sat;
   logic [THRESH_W-1:0] max_q;
   logic [THRESH_W-1:0] spark_q;
   logic                over_max;
   logic                over_spark;
   logic [FREQ_W-1:0]   freq_dec;
   logic                lp_dec;
   logic [COUNT_W-1:0]  pulses_next;
   logic [FREQ_W-1:0]   freq_div;
   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [DVD_W-1:0]    product;
   logic [DVS_W:0]      trial;
   logic                trial_ge;
   logic [DVS_W-1:0]    rem_step;
   logic [DVD_W-1:0]    dvd_step;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign csr_fire = csr_bus.valid && csr_bus.ready;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;

   assign idx_next = idx_ff + IDX_W'(1);
   assign sum_next = sum_ff + SUM_W'(req_bus.sample);

   // charge saturates to 19 bits for the average and the result only
   assign charge_sat = (charge_ff > EXACT_W'(CHARGE_MAX)) ? CHARGE_MAX
                                                          : charge_ff[CHARGE_W-1:0];
   assign max_q      = {max_uc_ff, 5'b00000};
   assign spark_q    = {spark_uc_ff, 5'b00000};
   assign over_max   = THRESH_W'(charge_ff) > max_q;
   assign over_spark = THRESH_W'(charge_ff) > spark_q;

   // zero frequency acts as one for the average
   assign freq_div = (freq_ff == '0) ? FREQ_W'(1) : freq_ff;

   // shared multiplier, operands picked by the sequencer
   always_comb begin
      mul_a = avg_ff;
      mul_b = freq_div - FREQ_W'(1);
      if (state_ff == ST_CHARGE) begin
         mul_a = MUL_A_W'(sum_ff);
         mul_b = CHARGE_MULT;
      end else begin
         case (op_ff)
            OP_AVG: begin
               mul_a = avg_ff;
               mul_b = freq_div - FREQ_W'(1);
            end
            OP_PWR: begin
               mul_a = avg_ff;
               mul_b = POWER_MULT;
            end
            OP_SPK: begin
               mul_a = MUL_A_W'(sparks_ff);
               mul_b = PCT_MULT;
            end
            default: begin
               mul_a = MUL_A_W'(shorts_ff);
               mul_b = PCT_MULT;
            end
         endcase
      end
   end

   assign product = DVD_W'(mul_a) * DVD_W'(mul_b);

   // one restoring divide step
   assign trial    = {rem_ff, dvd_ff[DVD_W-1]};
   assign trial_ge = trial >= {1'b0, dvs_ff};
   assign rem_step = trial_ge ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
   assign dvd_step = {dvd_ff[DVD_W-2:0], trial_ge};

   // mode decision for a closed pulse
   always_comb begin
      lp_dec   = lp_ff;
      freq_dec = freq_ff;
      if (over_max) begin
         if (!lp_ff) begin
            lp_dec   = 1'b1;
            freq_dec = lp_freq_ff;
         end
      end else if (lp_ff) begin
         lp_dec   = 1'b0;
         freq_dec = target_freq_ff;
      end
   end

   assign pulses_next = pulses_ff + COUNT_W'(1);

   // sequencer and next-state logic
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      idx_in         = idx_ff;
      sum_in         = sum_ff;
      lp_in          = lp_ff;
      freq_in        = freq_ff;
      pulses_in      = pulses_ff;
      sparks_in      = sparks_ff;
      shorts_in      = shorts_ff;
      avg_in         = avg_ff;
      spark_pct_in   = spark_pct_ff;
      short_pct_in   = short_pct_ff;
      charge_in      = charge_ff;
      short_in       = short_ff;
      spark_in       = spark_ff;
      changed_in     = changed_ff;
      done_in        = done_ff;
      power_in       = power_ff;
      dvd_in         = dvd_ff;
      rem_in         = rem_ff;
      dvs_in         = dvs_ff;
      cnt_in         = cnt_ff;
      target_freq_in = target_freq_ff;
      lp_freq_in     = lp_freq_ff;
      max_uc_in      = max_uc_ff;
      spark_uc_in    = spark_uc_ff;
      alert_pct_in   = alert_pct_ff;

      rsp_valid_in     = rsp_valid_ff && !rsp_bus.ready;
      rsp_charge_in    = rsp_charge_ff;
      rsp_short_in     = rsp_short_ff;
      rsp_spark_in     = rsp_spark_ff;
      rsp_lp_in        = rsp_lp_ff;
      rsp_changed_in   = rsp_changed_ff;
      rsp_freq_in      = rsp_freq_ff;
      rsp_avg_in       = rsp_avg_ff;
      rsp_power_in     = rsp_power_ff;
      rsp_done_in      = rsp_done_ff;
      rsp_spark_pct_in = rsp_spark_pct_ff;
      rsp_short_pct_in = rsp_short_pct_ff;
      rsp_alert_in     = rsp_alert_ff;

      // register writes; a new target applies at once outside low power mode
      if (csr_fire) begin
         unique case (csr_bus.index)
            CSR_TARGET_FREQ: begin
               target_freq_in = csr_bus.data;
               if (!lp_ff) begin
                  freq_in = csr_bus.data;
               end
            end
            CSR_LP_FREQ:   lp_freq_in   = csr_bus.data;
            CSR_MAX_UC:    max_uc_in    = csr_bus.data;
            CSR_SPARK_UC:  spark_uc_in  = csr_bus.data;
            CSR_ALERT_PCT: alert_pct_in = csr_bus.data[PCT_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (idx_next == IDX_W'(SAMPLES_PER_PULSE)) begin
                  sum_in   = sum_next;
                  idx_in   = '0;
                  state_in = ST_CHARGE;
               end else begin
                  sum_in = sum_next;
                  idx_in = idx_next;
               end
            end
         end

         ST_CHARGE: begin
            charge_in = product[EXACT_W-1:0];
            sum_in    = '0;
            state_in  = ST_DECIDE;
         end

         ST_DECIDE: begin
            lp_in      = lp_dec;
            freq_in    = freq_dec;
            changed_in = (lp_dec != lp_ff);
            short_in   = over_spark && over_max;
            spark_in   = over_spark && !over_max;
            pulses_in  = pulses_next;
            if (over_spark && over_max) begin
               shorts_in = shorts_ff + COUNT_W'(1);
            end
            if (over_spark && !over_max) begin
               sparks_in = sparks_ff + COUNT_W'(1);
            end
            // a lower frequency closes the window at this pulse if the count reaches it
            done_in  = (pulses_next >= freq_dec) && (pulses_next != '0);
            op_in    = OP_AVG;
            state_in = ST_MUL;
         end

         ST_MUL: begin
            rem_in   = '0;
            state_in = ST_DIV;
            case (op_ff)
               OP_AVG: begin
                  dvd_in = product + DVD_W'(charge_sat);
                  dvs_in = freq_div;
                  cnt_in = DIV_LONG;
               end
               OP_PWR: begin
                  dvd_in = product << DIV_ALIGN;
                  dvs_in = POWER_DIV;
                  cnt_in = DIV_SHORT;
               end
               default: begin
                  dvd_in = product << DIV_ALIGN;
                  dvs_in = pulses_ff;
                  cnt_in = DIV_SHORT;
               end
            endcase
         end

         ST_DIV: begin
            dvd_in = dvd_step;
            rem_in = rem_step;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               case (op_ff)
                  OP_AVG: begin
                     avg_in   = dvd_step[CHARGE_W-1:0];
                     op_in    = OP_PWR;
                     state_in = ST_MUL;
                  end
                  OP_PWR: begin
                     power_in = dvd_step[POWER_W-1:0];
                     if (done_ff) begin
                        op_in    = OP_SPK;
                        state_in = ST_MUL;
                     end else begin
                        state_in = ST_OUT;
                     end
                  end
                  OP_SPK: begin
                     spark_pct_in = dvd_step[PCT_W-1:0];
                     op_in        = OP_SHT;
                     state_in     = ST_MUL;
                  end
                  default: begin
                     short_pct_in = dvd_step[PCT_W-1:0];
                     pulses_in    = '0;
                     sparks_in    = '0;
                     shorts_in    = '0;
                     state_in     = ST_OUT;
                  end
               endcase
            end
         end

         ST_OUT: begin
            // load once the result register is free or being taken
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in     = 1'b1;
               rsp_charge_in    = charge_sat;
               rsp_short_in     = short_ff;
               rsp_spark_in     = spark_ff;
               rsp_lp_in        = lp_ff;
               rsp_changed_in   = changed_ff;
               rsp_freq_in      = freq_ff;
               rsp_avg_in       = avg_ff;
               rsp_power_in     = power_ff;
               rsp_done_in      = done_ff;
               rsp_spark_pct_in = spark_pct_ff;
               rsp_short_pct_in = short_pct_ff;
               rsp_alert_in     = short_pct_ff > alert_pct_ff;
               state_in         = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         op_ff          <= OP_AVG;
         idx_ff         <= '0;
         sum_ff         <= '0;
         lp_ff          <= 1'b0;
         freq_ff        <= TARGET_FREQ_RST;
         pulses_ff      <= '0;
         sparks_ff      <= '0;
         shorts_ff      <= '0;
         avg_ff         <= '0;
         spark_pct_ff   <= '0;
         short_pct_ff   <= '0;
         cnt_ff         <= '0;
         target_freq_ff <= TARGET_FREQ_RST;
         lp_freq_ff     <= LP_FREQ_RST;
         max_uc_ff      <= MAX_UC_RST;
         spark_uc_ff    <= SPARK_UC_RST;
         alert_pct_ff   <= ALERT_PCT_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         op_ff          <= op_in;
         idx_ff         <= idx_in;
         sum_ff         <= sum_in;
         lp_ff          <= lp_in;
         freq_ff        <= freq_in;
         pulses_ff      <= pulses_in;
         sparks_ff      <= sparks_in;
         shorts_ff      <= shorts_in;
         avg_ff         <= avg_in;
         spark_pct_ff   <= spark_pct_in;
         short_pct_ff   <= short_pct_in;
         cnt_ff         <= cnt_in;
         target_freq_ff <= target_freq_in;
         lp_freq_ff     <= lp_freq_in;
         max_uc_ff      <= max_uc_in;
         spark_uc_ff    <= spark_uc_in;
         alert_pct_ff   <= alert_pct_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      charge_ff        <= charge_in;
      short_ff         <= short_in;
      spark_ff         <= spark_in;
      changed_ff       <= changed_in;
      done_ff          <= done_in;
      power_ff         <= power_in;
      dvd_ff           <= dvd_in;
      rem_ff           <= rem_in;
      dvs_ff           <= dvs_in;
      rsp_charge_ff    <= rsp_charge_in;
      rsp_short_ff     <= rsp_short_in;
      rsp_spark_ff     <= rsp_spark_in;
      rsp_lp_ff        <= rsp_lp_in;
      rsp_changed_ff   <= rsp_changed_in;
      rsp_freq_ff      <= rsp_freq_in;
      rsp_avg_ff       <= rsp_avg_in;
      rsp_power_ff     <= rsp_power_in;
      rsp_done_ff      <= rsp_done_in;
      rsp_spark_pct_ff <= rsp_spark_pct_in;
      rsp_short_pct_ff <= rsp_short_pct_in;
      rsp_alert_ff     <= rsp_alert_in;
   end

   // result channel
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.charge_q        = rsp_charge_ff;
   assign rsp_bus.is_short        = rsp_short_ff;
   assign rsp_bus.is_spark        = rsp_spark_ff;
   assign rsp_bus.low_power       = rsp_lp_ff;
   assign rsp_bus.freq_changed    = rsp_changed_ff;
   assign rsp_bus.pulse_frequency = rsp_freq_ff;
   assign rsp_bus.avg_charge_q    = rsp_avg_ff;
   assign rsp_bus.power_mw        = rsp_power_ff;
   assign rsp_bus.window_done     = rsp_done_ff;
   assign rsp_bus.spark_pct       = rsp_spark_pct_ff;
   assign rsp_bus.short_pct       = rsp_short_pct_ff;
   assign rsp_bus.short_alert     = rsp_alert_ff;

endmodule
